// File: design/ssp_pkg.sv
// Shared types, constants and the microcode program of the shortest-path block.
// Used by ssp_seq and single_source_shortest_paths; depends on nothing.
package ssp_pkg;

    // Fixed field widths
    localparam int NODE_W  = 7;
    localparam int DIST_W  = 32;
    localparam int OPC_W   = 2;
    localparam int CFG_W   = 2;
    localparam int WIN_W   = 16;
    localparam int PC_W    = 4;

    // Parameter defaults
    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_EDGES   = 256;
    localparam int DEF_WEIGHT_BITS = 16;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPC_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_W-1:0] CFG_INFINITY   = 2'd2;

    // Register reset values
    localparam logic [NODE_W-1:0] RESET_NODE_COUNT = 7'd64;
    localparam logic [NODE_W-1:0] RESET_SOURCE     = 7'd1;
    localparam logic [DIST_W-1:0] RESET_INFINITY   = 32'd9999;

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        U_NOP,
        U_INIT,
        U_INIT_WR,
        U_ROUND,
        U_SCAN_RD,
        U_SCAN_CMP,
        U_SELECT,
        U_EDGE_RD,
        U_EDGE_CHK,
        U_RELAX,
        U_OUT_START,
        U_OUT_RD,
        U_OUT_EMIT,
        U_DONE
    } t_uop;

    // Jump condition of one microcode step
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_N_ZERO,
        C_I_NE_N,
        C_ROUND_DONE,
        C_SKIP_EDGES,
        C_E_NE_TOT
    } t_cond;

    typedef struct packed {
        t_uop            uop;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucw;

    // Status flags from datapath to sequencer
    typedef struct packed {
        logic n_zero;
        logic i_ne_n;
        logic round_done;
        logic skip_edges;
        logic e_ne_tot;
    } t_flags;

    // One entry of the per-node store
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] parent;
        logic              visited;
    } t_node_rec;

    // Program step addresses
    localparam logic [PC_W-1:0] ST_INIT      = 4'd0;
    localparam logic [PC_W-1:0] ST_INIT_WR   = 4'd1;
    localparam logic [PC_W-1:0] ST_ROUND     = 4'd2;
    localparam logic [PC_W-1:0] ST_SCAN_RD   = 4'd3;
    localparam logic [PC_W-1:0] ST_SCAN_CMP  = 4'd4;
    localparam logic [PC_W-1:0] ST_SELECT    = 4'd5;
    localparam logic [PC_W-1:0] ST_EDGE_RD   = 4'd6;
    localparam logic [PC_W-1:0] ST_EDGE_CHK  = 4'd7;
    localparam logic [PC_W-1:0] ST_RELAX     = 4'd8;
    localparam logic [PC_W-1:0] ST_NEXT_RND  = 4'd9;
    localparam logic [PC_W-1:0] ST_OUT_START = 4'd10;
    localparam logic [PC_W-1:0] ST_OUT_RD    = 4'd11;
    localparam logic [PC_W-1:0] ST_OUT_EMIT  = 4'd12;
    localparam logic [PC_W-1:0] ST_DONE      = 4'd13;

    localparam t_ucw UCW_IDLE = '{uop: U_NOP, cond: C_NONE, target: ST_INIT};

    // Microcode ROM
    function automatic t_ucw ucode_rom(input logic [PC_W-1:0] pc);
        t_ucw w;
        case (pc)
            ST_INIT:      w = '{uop: U_INIT,      cond: C_N_ZERO,     target: ST_DONE};
            ST_INIT_WR:   w = '{uop: U_INIT_WR,   cond: C_I_NE_N,     target: ST_INIT_WR};
            ST_ROUND:     w = '{uop: U_ROUND,     cond: C_ROUND_DONE, target: ST_OUT_START};
            ST_SCAN_RD:   w = '{uop: U_SCAN_RD,   cond: C_NONE,       target: ST_INIT};
            ST_SCAN_CMP:  w = '{uop: U_SCAN_CMP,  cond: C_I_NE_N,     target: ST_SCAN_RD};
            ST_SELECT:    w = '{uop: U_SELECT,    cond: C_SKIP_EDGES, target: ST_ROUND};
            ST_EDGE_RD:   w = '{uop: U_EDGE_RD,   cond: C_NONE,       target: ST_INIT};
            ST_EDGE_CHK:  w = '{uop: U_EDGE_CHK,  cond: C_NONE,       target: ST_INIT};
            ST_RELAX:     w = '{uop: U_RELAX,     cond: C_E_NE_TOT,   target: ST_EDGE_RD};
            ST_NEXT_RND:  w = '{uop: U_NOP,       cond: C_ALWAYS,     target: ST_ROUND};
            ST_OUT_START: w = '{uop: U_OUT_START, cond: C_NONE,       target: ST_INIT};
            ST_OUT_RD:    w = '{uop: U_OUT_RD,    cond: C_NONE,       target: ST_INIT};
            ST_OUT_EMIT:  w = '{uop: U_OUT_EMIT,  cond: C_I_NE_N,     target: ST_OUT_RD};
            ST_DONE:      w = '{uop: U_DONE,      cond: C_NONE,       target: ST_INIT};
            default:      w = '{uop: U_DONE,      cond: C_NONE,       target: ST_INIT};
        endcase
        return w;
    endfunction

endpackage

// File: design/ssp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ssp_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ssp_pkg.
module ssp_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  ssp_pkg::t_flags i_flags,
    output ssp_pkg::t_ucw   o_ucw,
    output logic            o_active
);

    logic [ssp_pkg::PC_W-1:0] r_pc;
    logic                     r_active;
    ssp_pkg::t_ucw            w_ucw;
    logic                     w_take;

    assign w_ucw = ssp_pkg::ucode_rom(r_pc);

    // Jump condition select
    always_comb begin
        case (w_ucw.cond)
            ssp_pkg::C_NONE:       w_take = 1'b0;
            ssp_pkg::C_ALWAYS:     w_take = 1'b1;
            ssp_pkg::C_N_ZERO:     w_take = i_flags.n_zero;
            ssp_pkg::C_I_NE_N:     w_take = i_flags.i_ne_n;
            ssp_pkg::C_ROUND_DONE: w_take = i_flags.round_done;
            ssp_pkg::C_SKIP_EDGES: w_take = i_flags.skip_edges;
            ssp_pkg::C_E_NE_TOT:   w_take = i_flags.e_ne_tot;
            default:               w_take = 1'b0;
        endcase
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pc     <= ssp_pkg::ST_INIT;
        end else if (!r_active) begin
            if (i_go) begin
                r_active <= 1'b1;
                r_pc     <= ssp_pkg::ST_INIT;
            end
        end else begin
            if (w_ucw.uop == ssp_pkg::U_DONE) begin
                r_active <= 1'b0;
            end
            r_pc <= w_take ? w_ucw.target : r_pc + 1'b1;
        end
    end

    assign o_ucw    = r_active ? w_ucw : ssp_pkg::UCW_IDLE;
    assign o_active = r_active;

endmodule

// File: design/single_source_shortest_paths.sv
// Top level of the single-source shortest-path block: edge store, node store,
// datapath and microcode sequencer. Depends on ssp_pkg, ssp_ram and ssp_seq.
//
// Add-edge and clear commands leave busy low, so edges load one per cycle
// while no run is in progress. A run command raises busy and is executed by a
// microcode program over the node memory (one write port, one read port) and
// the edge memory. Each round scans the node memory node by node for the
// unvisited node with the smallest distance and, unless it finds none or no
// edges are stored, walks the stored edges to relax the far ends of those
// that touch it. The n results come out one at a time near the end of the run,
// each for exactly one cycle marked by o_valid; the receiver cannot stall
// them. busy falls in the cycle after the last result.
// Configuration is taken at any time (o_cfg_ready is always high) but must only
// change while idle.
module single_source_shortest_paths #(
    parameter int MAX_NODES   = ssp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = ssp_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = ssp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [ssp_pkg::OPC_W-1:0]        i_opcode,
    input  logic [ssp_pkg::NODE_W-1:0]       i_end_a,
    input  logic [ssp_pkg::NODE_W-1:0]       i_end_b,
    input  logic [ssp_pkg::WIN_W-1:0]        i_weight,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssp_pkg::CFG_W-1:0]        i_cfg_index,
    input  logic [ssp_pkg::DIST_W-1:0]       i_cfg_data,
    // results
    output logic                             o_valid,
    output logic [ssp_pkg::NODE_W-1:0]       o_node,
    output logic [ssp_pkg::DIST_W-1:0]       o_distance,
    output logic [ssp_pkg::NODE_W-1:0]       o_parent,
    output logic                             o_last
);

    localparam int NW  = ssp_pkg::NODE_W;
    localparam int DW  = ssp_pkg::DIST_W;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NW + WEIGHT_BITS;
    localparam int RW  = DW + NW + 1;
    localparam logic [NW-1:0]  MAXN = NW'(MAX_NODES);
    localparam logic [ETW-1:0] MAXE = ETW'(MAX_EDGES);

    // Configuration registers
    logic [NW-1:0] r_node_count;
    logic [NW-1:0] r_source;
    logic [DW-1:0] r_inf;

    // Datapath registers
    logic [ETW-1:0]       r_etot;
    logic [ETW-1:0]       r_e;
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_i;
    logic [NW-1:0]        r_round;
    logic [NW-1:0]        r_u;
    logic [NW-1:0]        r_upar;
    logic [NW-1:0]        r_v;
    logic                 r_hit;
    logic [DW-1:0]        r_best;
    logic [DW-1:0]        r_du;

    // Output registers
    logic          r_valid;
    logic [NW-1:0] r_out_node;
    logic [DW-1:0] r_out_dist;
    logic [NW-1:0] r_out_parent;
    logic          r_out_last;

    ssp_pkg::t_ucw   w_ucw;
    ssp_pkg::t_flags w_flags;
    logic            w_active;
    logic            w_accept;
    logic            w_go;
    logic [NW-1:0]   w_n_cfg;

    // Edge memory ports
    logic           w_e_we;
    logic [EAW-1:0] w_e_waddr;
    logic [EW-1:0]  w_e_wdata;
    logic           w_e_re;
    logic [EW-1:0]  w_e_q;
    logic [31:0]    w_win;

    // Node memory ports
    logic               w_nd_we;
    logic [NAW-1:0]     w_nd_waddr;
    ssp_pkg::t_node_rec w_nd_wrec;
    logic               w_nd_re;
    logic [NAW-1:0]     w_nd_raddr;
    logic [RW-1:0]      w_nd_q;
    ssp_pkg::t_node_rec w_nd_rec;

    // Edge decode and relaxation
    logic [NW-1:0]          w_ea;
    logic [NW-1:0]          w_eb;
    logic [WEIGHT_BITS-1:0] w_ew;
    logic                   w_in_range;
    logic                   w_hit_a;
    logic                   w_hit_b;
    logic [NW-1:0]          w_v;
    logic [DW:0]            w_sum;
    logic [DW-1:0]          w_cand;
    logic [NW-1:0]          w_im1;
    logic [NW-1:0]          w_vm1;
    logic [NW-1:0]          w_rvm1;
    logic [NW-1:0]          w_um1;
    logic                   w_better;

    assign w_accept = start && !busy;
    assign w_go     = w_accept && (i_opcode == ssp_pkg::OP_RUN);
    assign w_n_cfg  = (r_node_count > MAXN) ? MAXN : r_node_count;

    // Sequencer
    ssp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_flags  (w_flags),
        .o_ucw    (w_ucw),
        .o_active (w_active)
    );

    assign w_flags.n_zero     = (w_n_cfg == '0);
    assign w_flags.i_ne_n     = (r_i != r_n);
    assign w_flags.round_done = (r_round == r_n);
    assign w_flags.skip_edges = (r_u == '0) || (r_etot == '0);
    assign w_flags.e_ne_tot   = (r_e != r_etot);

    // Edge memory: written on add commands, read during the edge walk
    assign w_win     = 32'(i_weight);
    assign w_e_we    = w_accept && (i_opcode == ssp_pkg::OP_ADD) && (r_etot < MAXE);
    assign w_e_waddr = r_etot[EAW-1:0];
    assign w_e_wdata = {i_end_a, i_end_b, w_win[WEIGHT_BITS-1:0]};
    assign w_e_re    = (w_ucw.uop == ssp_pkg::U_EDGE_RD);

    ssp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_e_we),
        .i_waddr (w_e_waddr),
        .i_wdata (w_e_wdata),
        .i_re    (w_e_re),
        .i_raddr (r_e[EAW-1:0]),
        .o_rdata (w_e_q)
    );

    // Edge decode: pick the far end of an edge that touches the selected node
    assign w_ea       = w_e_q[EW-1 -: NW];
    assign w_eb       = w_e_q[WEIGHT_BITS +: NW];
    assign w_ew       = w_e_q[WEIGHT_BITS-1:0];
    assign w_in_range = (w_ea != '0) && (w_ea <= r_n) && (w_eb != '0) && (w_eb <= r_n);
    assign w_hit_a    = (w_ea == r_u);
    assign w_hit_b    = (w_eb == r_u);
    assign w_v        = w_hit_a ? w_eb : w_ea;

    // Saturating candidate distance and strict improvement test
    assign w_sum    = {1'b0, r_du} + (DW+1)'(w_ew);
    assign w_cand   = w_sum[DW] ? '1 : w_sum[DW-1:0];
    assign w_nd_rec = ssp_pkg::t_node_rec'(w_nd_q);
    assign w_better = r_hit && (w_nd_rec.distance > w_cand);

    assign w_im1  = r_i - 1'b1;
    assign w_vm1  = w_v - 1'b1;
    assign w_rvm1 = r_v - 1'b1;
    assign w_um1  = r_u - 1'b1;

    // Node memory port control
    always_comb begin
        w_nd_we            = 1'b0;
        w_nd_waddr         = w_im1[NAW-1:0];
        w_nd_wrec.distance = (r_i == r_source) ? '0 : r_inf;
        w_nd_wrec.parent   = '0;
        w_nd_wrec.visited  = 1'b0;
        w_nd_re            = 1'b0;
        w_nd_raddr         = w_im1[NAW-1:0];
        case (w_ucw.uop)
            ssp_pkg::U_INIT_WR: begin
                w_nd_we = 1'b1;
            end
            ssp_pkg::U_SCAN_RD, ssp_pkg::U_OUT_RD: begin
                w_nd_re = 1'b1;
            end
            // mark the selected node visited, keeping its distance and parent
            ssp_pkg::U_SELECT: begin
                w_nd_we            = (r_u != '0);
                w_nd_waddr         = w_um1[NAW-1:0];
                w_nd_wrec.distance = r_best;
                w_nd_wrec.parent   = r_upar;
                w_nd_wrec.visited  = 1'b1;
            end
            ssp_pkg::U_EDGE_CHK: begin
                w_nd_re    = 1'b1;
                w_nd_raddr = w_vm1[NAW-1:0];
            end
            ssp_pkg::U_RELAX: begin
                w_nd_we            = w_better;
                w_nd_waddr         = w_rvm1[NAW-1:0];
                w_nd_wrec.distance = w_cand;
                w_nd_wrec.parent   = r_u;
                w_nd_wrec.visited  = w_nd_rec.visited;
            end
            default: begin
            end
        endcase
    end

    ssp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_nd_we),
        .i_waddr (w_nd_waddr),
        .i_wdata (RW'(w_nd_wrec)),
        .i_re    (w_nd_re),
        .i_raddr (w_nd_raddr),
        .o_rdata (w_nd_q)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ssp_pkg::RESET_NODE_COUNT;
            r_source     <= ssp_pkg::RESET_SOURCE;
            r_inf        <= ssp_pkg::RESET_INFINITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssp_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[NW-1:0];
                ssp_pkg::CFG_SOURCE:     r_source     <= i_cfg_data[NW-1:0];
                ssp_pkg::CFG_INFINITY:   r_inf        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Edge count: add and clear commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etot <= '0;
        end else if (w_e_we) begin
            r_etot <= r_etot + 1'b1;
        end else if (w_accept && (i_opcode == ssp_pkg::OP_CLEAR)) begin
            r_etot <= '0;
        end
    end

    // Datapath registers driven by the current control word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_i       <= '0;
            r_round   <= '0;
            r_u       <= '0;
            r_e       <= '0;
            r_hit     <= 1'b0;
        end else begin
            case (w_ucw.uop)
                ssp_pkg::U_INIT: begin
                    r_n       <= w_n_cfg;
                    r_i       <= NW'(1);
                    r_round   <= '0;
                end
                ssp_pkg::U_INIT_WR, ssp_pkg::U_OUT_EMIT: begin
                    r_i <= r_i + 1'b1;
                end
                ssp_pkg::U_ROUND: begin
                    r_i    <= NW'(1);
                    r_best <= r_inf;
                    r_u    <= '0;
                end
                ssp_pkg::U_SCAN_CMP: begin
                    if (!w_nd_rec.visited && (w_nd_rec.distance < r_best)) begin
                        r_best <= w_nd_rec.distance;
                        r_u    <= r_i;
                        r_upar <= w_nd_rec.parent;
                    end
                    r_i <= r_i + 1'b1;
                end
                ssp_pkg::U_SELECT: begin
                    r_round <= r_round + 1'b1;
                    r_du    <= r_best;
                    r_e     <= '0;
                end
                ssp_pkg::U_EDGE_CHK: begin
                    r_v   <= w_v;
                    r_hit <= w_in_range && (w_hit_a || w_hit_b);
                    r_e   <= r_e + 1'b1;
                end
                ssp_pkg::U_OUT_START: begin
                    r_i <= NW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Result registers: one strobed transfer per node
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_ucw.uop == ssp_pkg::U_OUT_EMIT);
        end
        if (w_ucw.uop == ssp_pkg::U_OUT_EMIT) begin
            r_out_node   <= r_i;
            r_out_dist   <= w_nd_rec.distance;
            r_out_parent <= w_nd_rec.parent;
            r_out_last   <= (r_i == r_n);
        end
    end

    assign busy        = w_active;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_node      = r_out_node;
    assign o_distance  = r_out_dist;
    assign o_parent    = r_out_parent;
    assign o_last      = r_out_last;

endmodule

// File: verif/tb_single_source_shortest_paths.sv
`timescale 1ns / 1ps
// Self-checking testbench for single_source_shortest_paths: loads edge sets, runs
// the path search and checks every node result against a scoreboard predictor.
// Depends on ssp_pkg and the block's RTL only.
module tb_single_source_shortest_paths;
    import ssp_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [OPC_W-1:0] OP_UNUSED  = 2'd3;
    localparam logic [CFG_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 136;
    localparam int DRAIN_LIMIT  = 200000;

    // One node result of a run
    typedef struct {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] parent;
        logic              last;
    } t_path_result;

    // Scoreboard: keeps its own copy of registers and edge store, predicts the
    // results of each accepted command and checks results in arrival order.
    class t_path_scoreboard;
        logic [NODE_W-1:0] node_count_q;
        logic [NODE_W-1:0] source_q;
        logic [DIST_W-1:0] infinity_q;
        logic [NODE_W-1:0] first_end [DEF_MAX_EDGES];
        logic [NODE_W-1:0] second_end [DEF_MAX_EDGES];
        logic [WIN_W-1:0]  edge_wt [DEF_MAX_EDGES];
        int                edge_cnt;
        logic [DIST_W-1:0] dist_of [DEF_MAX_NODES+1];
        logic [NODE_W-1:0] parent_of [DEF_MAX_NODES+1];
        bit                visited [DEF_MAX_NODES+1];
        t_path_result      pending [$];
        int                errors;

        function new();
            node_count_q = RESET_NODE_COUNT;
            source_q     = RESET_SOURCE;
            infinity_q   = RESET_INFINITY;
            edge_cnt     = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_W-1:0] idx, logic [DIST_W-1:0] data);
            case (idx)
                CFG_NODE_COUNT: node_count_q = data[NODE_W-1:0];
                CFG_SOURCE:     source_q = data[NODE_W-1:0];
                CFG_INFINITY:   infinity_q = data;
                default: ;
            endcase
        endfunction

        // Strict-improvement relaxation with a saturating sum
        function void relax(int u, int v, logic [WIN_W-1:0] w);
            logic [DIST_W:0]   sum;
            logic [DIST_W-1:0] cand;
            sum  = dist_of[u] + w;
            cand = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
            if (dist_of[v] > cand) begin
                dist_of[v]   = cand;
                parent_of[v] = NODE_W'(u);
            end
        endfunction

        // Array-scan Dijkstra over the stored edges, then one result per node
        function void run_paths();
            int                n, r, i, k, u, a, b;
            logic [DIST_W-1:0] best;
            t_path_result      res;
            n = (node_count_q > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(node_count_q);
            for (i = 1; i <= n; i++) begin
                dist_of[i]   = infinity_q;
                parent_of[i] = '0;
                visited[i]   = 1'b0;
            end
            if (source_q >= 1 && source_q <= n)
                dist_of[source_q] = '0;
            for (r = 0; r < n; r++) begin
                best = infinity_q;
                u    = 0;
                for (i = 1; i <= n; i++) begin
                    if (!visited[i] && dist_of[i] < best) begin
                        best = dist_of[i];
                        u    = i;
                    end
                end
                // a round with nothing selectable leaves everything as is
                if (u != 0) begin
                    visited[u] = 1'b1;
                    for (k = 0; k < edge_cnt; k++) begin
                        a = first_end[k];
                        b = second_end[k];
                        if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                            if (a == u) relax(u, b, edge_wt[k]);
                            if (b == u) relax(u, a, edge_wt[k]);
                        end
                    end
                end
            end
            for (i = 1; i <= n; i++) begin
                res.node     = NODE_W'(i);
                res.distance = dist_of[i];
                res.parent   = parent_of[i];
                res.last     = (i == n);
                pending      = {pending, res};
            end
        endfunction

        // Called for every accepted command transfer
        function void note_command(logic [OPC_W-1:0] op, logic [NODE_W-1:0] a,
                                   logic [NODE_W-1:0] b, logic [WIN_W-1:0] w);
            case (op)
                OP_ADD: begin
                    // adds to a full store are dropped
                    if (edge_cnt < DEF_MAX_EDGES) begin
                        first_end[edge_cnt]  = a;
                        second_end[edge_cnt] = b;
                        edge_wt[edge_cnt]    = w;
                        edge_cnt++;
                    end
                end
                OP_RUN:   run_paths();
                OP_CLEAR: edge_cnt = 0;
                default: ;
            endcase
        endfunction

        // Called for every result transfer
        function void check_result(logic [NODE_W-1:0] node, logic [DIST_W-1:0] dist_got,
                                   logic [NODE_W-1:0] par, logic last);
            t_path_result want;
            if (pending.size() == 0) begin
                $error("unexpected result: node %0d distance %0d parent %0d",
                       node, dist_got, par);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (node !== want.node) begin
                $error("node: expected %0d, got %0d", want.node, node);
                errors++;
            end
            if (dist_got !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, dist_got);
                errors++;
            end
            if (par !== want.parent) begin
                $error("parent: expected %0d, got %0d", want.parent, par);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    // DUT signals
    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [OPC_W-1:0]    i_opcode    = '0;
    logic [NODE_W-1:0]   i_end_a     = '0;
    logic [NODE_W-1:0]   i_end_b     = '0;
    logic [WIN_W-1:0]    i_weight    = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_index = '0;
    logic [DIST_W-1:0]   i_cfg_data  = '0;
    logic                o_valid;
    logic [NODE_W-1:0]   o_node;
    logic [DIST_W-1:0]   o_distance;
    logic [NODE_W-1:0]   o_parent;
    logic                o_last;

    t_path_scoreboard sb;
    int               sender_idle_pct = 0;
    int               cur_nodes = DEF_MAX_NODES;

    single_source_shortest_paths uut (.*);

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result monitor: results cannot be stalled, check each strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_node, o_distance, o_parent, o_last);
    end

    // Hard stop
    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // One command transfer, with optional idle cycles in front
    task automatic send_cmd(logic [OPC_W-1:0] op, logic [NODE_W-1:0] a,
                            logic [NODE_W-1:0] b, logic [WIN_W-1:0] w);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_end_a  <= a;
        i_end_b  <= b;
        i_weight <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, a, b, w);
    endtask

    // Command whose edge fields are don't-care
    task automatic send_ctrl(logic [OPC_W-1:0] op);
        send_cmd(op, NODE_W'($urandom()), NODE_W'($urandom()), WIN_W'($urandom()));
    endtask

    // Block idle: all results in and busy low
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_W-1:0] idx, logic [DIST_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Noise in the bits above a 7-bit register
    function automatic logic [DIST_W-1:0] upper_noise();
        return $urandom_range(0, 1) ? (DIST_W'($urandom()) & 32'hFFFF_FF80) : '0;
    endfunction

    task automatic configure(int n, int src, logic [DIST_W-1:0] inf);
        wait_idle();
        cfg_write(CFG_NODE_COUNT, upper_noise() | DIST_W'(n & 'h7F));
        cfg_write(CFG_SOURCE, upper_noise() | DIST_W'(src & 'h7F));
        cfg_write(CFG_INFINITY, inf);
        if ($urandom_range(0, 5) == 0)
            cfg_write(CFG_UNUSED, DIST_W'($urandom()));
        i_cfg_valid <= 1'b0;
        cur_nodes = ((n & 'h7F) > DEF_MAX_NODES) ? DEF_MAX_NODES : (n & 'h7F);
    endtask

    task automatic run_under(int n, int src, logic [DIST_W-1:0] inf);
        configure(n, src, inf);
        send_ctrl(OP_RUN);
    endtask

    // Endpoint, mostly inside the nodes in use
    function automatic logic [NODE_W-1:0] pick_end();
        if ($urandom_range(0, 9) == 0)
            return NODE_W'($urandom());
        return NODE_W'($urandom_range(1, (cur_nodes < 1) ? 1 : cur_nodes));
    endfunction

    function automatic logic [WIN_W-1:0] pick_weight();
        return $urandom_range(0, 1) ? WIN_W'($urandom()) : WIN_W'($urandom_range(0, 30));
    endfunction

    // Stimulus
    initial begin
        int                idle_pcts [3];
        int                items, seq, k, n, src, guard;
        logic [OPC_W-1:0]  op;
        logic [DIST_W-1:0] inf;

        idle_pcts = '{0, 46, 12};
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store with reset settings, only the source is reached
        send_ctrl(OP_RUN);
        send_ctrl(OP_CLEAR);

        // Small graph with self-loop, out-of-range ends, zero and full weights
        configure(6, 1, RESET_INFINITY);
        send_cmd(OP_ADD, 7'd1, 7'd2, 16'd7);
        send_cmd(OP_ADD, 7'd1, 7'd3, 16'd9);
        send_cmd(OP_ADD, 7'd1, 7'd6, 16'd14);
        send_cmd(OP_ADD, 7'd2, 7'd3, 16'd10);
        send_cmd(OP_ADD, 7'd2, 7'd4, 16'd15);
        send_cmd(OP_ADD, 7'd3, 7'd4, 16'd11);
        send_cmd(OP_ADD, 7'd3, 7'd6, 16'd2);
        send_cmd(OP_ADD, 7'd4, 7'd5, 16'd6);
        send_cmd(OP_ADD, 7'd5, 7'd6, 16'd9);
        send_cmd(OP_ADD, 7'd2, 7'd2, 16'd0);
        send_cmd(OP_ADD, 7'd0, 7'd5, 16'd1);
        send_cmd(OP_ADD, 7'd3, 7'd127, 16'd1);
        send_cmd(OP_ADD, 7'd6, 7'd5, 16'hFFFF);
        send_cmd(OP_ADD, 7'd4, 7'd5, 16'd0);
        send_ctrl(OP_UNUSED);
        send_ctrl(OP_RUN);

        // Infinity zero and one, source out of range, zero and oversized node count
        run_under(6, 1, 32'd0);
        run_under(6, 1, 32'd1);
        run_under(6, 0, RESET_INFINITY);
        run_under(6, 100, RESET_INFINITY);
        run_under(0, 1, RESET_INFINITY);
        run_under(127, 3, 32'hFFFF_FFFF);

        // Random: mostly clear/load/run sequences, some noise
        items = 0;
        seq   = 0;
        while (items < RANDOM_ITEMS) begin
            sender_idle_pct = idle_pcts[seq % 3];
            if (seq % 3 == 0 || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 19))
                    0:       n = 0;
                    1:       n = $urandom_range(65, 127);
                    2, 3:    n = $urandom_range(17, 64);
                    default: n = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 9))
                    0:       src = 0;
                    1:       src = $urandom_range(0, 127);
                    default: src = $urandom_range(1, (n < 1) ? 1 : ((n > 64) ? 64 : n));
                endcase
                case ($urandom_range(0, 5))
                    0:       inf = RESET_INFINITY;
                    1:       inf = 32'hFFFF_FFFF;
                    2:       inf = DIST_W'($urandom());
                    3:       inf = DIST_W'($urandom_range(0, 40));
                    default: inf = DIST_W'($urandom_range(1000, 2000000));
                endcase
                configure(n, src, inf);
            end
            if ($urandom_range(0, 4) != 0) begin
                if (sb.edge_cnt > 40 || $urandom_range(0, 1)) begin
                    send_ctrl(OP_CLEAR);
                    items++;
                end
                k = $urandom_range(0, 16);
                repeat (k) begin
                    send_cmd(OP_ADD, pick_end(), pick_end(), pick_weight());
                    items++;
                end
                if ($urandom_range(0, 5) == 0)
                    send_ctrl(OP_UNUSED);
            end else begin
                // noise: any opcode, any field values
                k = $urandom_range(1, 6);
                repeat (k) begin
                    op = OPC_W'($urandom());
                    send_cmd(op, NODE_W'($urandom()), NODE_W'($urandom()),
                             WIN_W'($urandom()));
                    if (op != OP_UNUSED)
                        items++;
                end
            end
            send_ctrl(OP_RUN);
            items++;
            seq++;
        end

        // Drain outstanding results
        start <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
